FILE: hdl/sphere_obb_overlap_test_top_assert.svh
// Assertion macros for the sphere versus oriented box overlap test.
// Used by the port checker; needs a clock named clk and a reset named rst in scope.
`ifndef SPHERE_OBB_OVERLAP_TEST_TOP_ASSERT_SVH
`define SPHERE_OBB_OVERLAP_TEST_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define SOT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SOT_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sot_pkg.sv
// Package for the sphere versus oriented box overlap test: widths, field offsets,
// datapath types and the component unpack function. Depends on nothing.
`default_nettype none

package sot_pkg;

  // Field and datapath widths
  localparam int CompW   = 21;
  localparam int VecW    = 3 * CompW;
  localparam int RadW    = 20;
  localparam int ExtW    = 20;
  localparam int DiffW   = 22;
  localparam int Prod1W  = DiffW + CompW;
  localparam int ProjW   = Prod1W + 2;
  localparam int ExtSh   = 19;
  localparam int ClampW  = ExtW + ExtSh + 1;
  localparam int Prod2W  = ClampW + CompW;
  localparam int WorldW  = Prod2W + 2;
  localparam int ResSh   = 38;
  localparam int ResW    = 64;
  localparam int RndSh   = 32;
  localparam int MagW    = ResW - RndSh;
  localparam int SqW     = 2 * MagW;
  localparam int SumW    = SqW + 2;
  localparam int RadSqW  = 2 * RadW;
  localparam int RadSh   = 12;
  localparam int Rad2W   = RadSqW + RadSh;
  localparam int Stages  = 8;

  // Input word layout, lowest field first, padded to whole bytes
  localparam int SphCenLsb = 0;
  localparam int RadLsb    = SphCenLsb + VecW;
  localparam int BoxCenLsb = RadLsb + RadW;
  localparam int AxXLsb    = BoxCenLsb + VecW;
  localparam int AxYLsb    = AxXLsb + VecW;
  localparam int AxZLsb    = AxYLsb + VecW;
  localparam int HalfLsb   = AxZLsb + VecW;
  localparam int InBits    = HalfLsb + VecW;
  localparam int InW       = ((InBits + 7) / 8) * 8;
  localparam int OutW      = 8;

  typedef logic signed [CompW-1:0]  comp_t;
  typedef logic        [VecW-1:0]   vec_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic        [ExtW-1:0]   ext_t;
  typedef logic signed [Prod1W-1:0] prod1_t;
  typedef logic signed [ClampW-1:0] clamp_t;
  typedef logic signed [Prod2W-1:0] prod2_t;
  typedef logic signed [ResW-1:0]   res_t;
  typedef logic        [MagW-1:0]   mag_t;
  typedef logic        [SqW-1:0]    sq_t;
  typedef logic        [Rad2W-1:0]  rad2_t;

  // One signed component out of a packed x,y,z vector
  function automatic comp_t comp_get(vec_t v, logic [1:0] idx);
    comp_get = comp_t'(v[CompW*idx +: CompW]);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sphere_obb_overlap_test_top.sv
// Sphere versus oriented box overlap test, fully pipelined top level.
// Depends on sot_pkg.
//
// Usage:
//   Slave channel s_*: one item per accepted beat, carrying a sphere (centre
//   and radius) and an oriented box (centre, three axes, half extents).
//   Master channel m_*: one result item per input item, in input order;
//   m_tdata[0] is 1 when the sphere touches or overlaps the box.
//   With no stall an accepted item passes through the stage registers in
//   order. Throughput is one item per cycle while m_tready stays high;
//   eight register stages, each holding at most one multiplier row or one
//   wide add with a compare, set the clock.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles are squeezed out and s_tready stays high while the pipe has room,
//   even with a result waiting at the output.
//   When the receiver holds m_tready low the output item is held and the
//   stages behind it fill up; nothing is dropped or repeated.
//   A synchronous reset empties the pipeline; m_tvalid is low afterwards.
`default_nettype none

module sphere_obb_overlap_test_top
  import sot_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  // sphere_center[62:0], sphere_radius[82:63], box_center[145:83],
  // box_axis_x[208:146], box_axis_y[271:209], box_axis_z[334:272],
  // box_half_extent[397:335], zero padding[399:398]
  input  wire logic [InW-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  // overlap[0], zero padding[7:1]
  output logic [OutW-1:0]      m_tdata
);

  // Stage valid bits and advance enables
  logic [Stages:1] vld;
  logic [Stages+1:1] adv;

  always_comb begin
    adv[Stages+1] = m_tready;
    for (int k = Stages; k >= 1; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  assign s_tready = adv[1];
  assign m_tvalid = vld[Stages];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= Stages; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: unpack, centre difference, clamp negative half extents to zero
  diff_t s1_d     [3];
  comp_t s1_ax    [3][3];
  ext_t  s1_e     [3];
  logic [RadW-1:0] s1_rad;

  diff_t s1_d_next  [3];
  comp_t s1_ax_next [3][3];
  ext_t  s1_e_next  [3];

  always_comb begin
    comp_t he;
    for (int i = 0; i < 3; i++) begin
      s1_d_next[i] = DiffW'(comp_get(s_tdata[SphCenLsb +: VecW], 2'(i)))
                   - DiffW'(comp_get(s_tdata[BoxCenLsb +: VecW], 2'(i)));
      s1_ax_next[0][i] = comp_get(s_tdata[AxXLsb +: VecW], 2'(i));
      s1_ax_next[1][i] = comp_get(s_tdata[AxYLsb +: VecW], 2'(i));
      s1_ax_next[2][i] = comp_get(s_tdata[AxZLsb +: VecW], 2'(i));
      he = comp_get(s_tdata[HalfLsb +: VecW], 2'(i));
      s1_e_next[i] = he[CompW-1] ? '0 : he[ExtW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_d   <= s1_d_next;
      s1_ax  <= s1_ax_next;
      s1_e   <= s1_e_next;
      s1_rad <= s_tdata[RadLsb +: RadW];
    end
  end

  // Stage 2: nine products of difference and axis components, radius squared
  prod1_t s2_prod [3][3];
  diff_t  s2_d    [3];
  comp_t  s2_ax   [3][3];
  ext_t   s2_e    [3];
  rad2_t  s2_rad2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          s2_prod[k][i] <= Prod1W'(s1_d[i]) * Prod1W'(s1_ax[k][i]);
        end
      end
      s2_d    <= s1_d;
      s2_ax   <= s1_ax;
      s2_e    <= s1_e;
      s2_rad2 <= {RadSqW'(s1_rad) * RadSqW'(s1_rad), RadSh'(0)};
    end
  end

  // Stage 3: projections onto the box axes, clamped to the half extents
  clamp_t s3_c  [3];
  diff_t  s3_d  [3];
  comp_t  s3_ax [3][3];
  rad2_t  s3_rad2;

  clamp_t s3_c_next [3];

  always_comb begin
    logic signed [ProjW-1:0] p;
    logic signed [ProjW-1:0] lim;
    logic signed [ProjW-1:0] nlim;
    for (int k = 0; k < 3; k++) begin
      p = ProjW'(s2_prod[k][0]) + ProjW'(s2_prod[k][1]) + ProjW'(s2_prod[k][2]);
      lim  = ProjW'($signed({1'b0, s2_e[k], ExtSh'(0)}));
      nlim = -lim;
      if (p > lim) begin
        s3_c_next[k] = lim[ClampW-1:0];
      end else if (p < nlim) begin
        s3_c_next[k] = nlim[ClampW-1:0];
      end else begin
        s3_c_next[k] = p[ClampW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_c    <= s3_c_next;
      s3_d    <= s2_d;
      s3_ax   <= s2_ax;
      s3_rad2 <= s2_rad2;
    end
  end

  // Stage 4: nine products that rebuild the closest point in world space
  prod2_t s4_prod [3][3];
  diff_t  s4_d    [3];
  rad2_t  s4_rad2;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          s4_prod[k][i] <= Prod2W'(s3_c[k]) * Prod2W'(s3_ax[k][i]);
        end
      end
      s4_d    <= s3_d;
      s4_rad2 <= s3_rad2;
    end
  end

  // Stage 5: residual between the sphere centre and the closest point
  res_t  s5_r [3];
  rad2_t s5_rad2;

  res_t s5_r_next [3];

  always_comb begin
    logic signed [WorldW-1:0] w;
    for (int i = 0; i < 3; i++) begin
      w = WorldW'(s4_prod[0][i]) + WorldW'(s4_prod[1][i]) + WorldW'(s4_prod[2][i]);
      s5_r_next[i] = ResW'($signed({s4_d[i], ResSh'(0)})) - ResW'(w);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_r    <= s5_r_next;
      s5_rad2 <= s4_rad2;
    end
  end

  // Stage 6: magnitude, rounded half away from zero to scale 2^-6
  mag_t  s6_m [3];
  rad2_t s6_rad2;

  mag_t s6_m_next [3];

  always_comb begin
    logic [ResW-1:0] mag;
    logic [ResW-1:0] rnd;
    for (int i = 0; i < 3; i++) begin
      mag = s5_r[i][ResW-1] ? ResW'(-s5_r[i]) : ResW'(s5_r[i]);
      rnd = mag + (ResW'(1) << (RndSh - 1));
      s6_m_next[i] = rnd[ResW-1:RndSh];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_m    <= s6_m_next;
      s6_rad2 <= s5_rad2;
    end
  end

  // Stage 7: squares of the three residual components
  sq_t   s7_sq [3];
  rad2_t s7_rad2;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int i = 0; i < 3; i++) begin
        s7_sq[i] <= SqW'(s6_m[i]) * SqW'(s6_m[i]);
      end
      s7_rad2 <= s6_rad2;
    end
  end

  // Stage 8: squared distance against squared radius, equality is a hit
  logic s8_ovl;
  logic [SumW-1:0] dist2;

  assign dist2 = SumW'(s7_sq[0]) + SumW'(s7_sq[1]) + SumW'(s7_sq[2]);

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_ovl <= (dist2 <= SumW'(s7_rad2));
    end
  end

  assign m_tdata = {(OutW-1)'(0), s8_ovl};

endmodule

`default_nettype wire

FILE: hdl/sot_checker.sv
// Port checker for the sphere versus oriented box overlap test, bound to the top level.
// Depends on sot_pkg and the assertion macros in sphere_obb_overlap_test_top_assert.svh.
`default_nettype none

`include "sphere_obb_overlap_test_top_assert.svh"

module sot_checker
  import sot_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            s_tvalid,
  input wire logic            s_tready,
  input wire logic [InW-1:0]  s_tdata,
  input wire logic            m_tvalid,
  input wire logic            m_tready,
  input wire logic [OutW-1:0] m_tdata
);

  // A stalled result item stays offered and unchanged.
  `SOT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item dropped or changed while stalled")

  // With the receiver ready every stage can advance, so the input is ready too.
  `SOT_ASSERT_IMPL(a_ready_chain, m_tready, s_tready, "input stalled while the receiver is ready")

  // Padding bits of a result item are zero.
  `SOT_ASSERT_IMPL(a_out_pad, m_tvalid, m_tdata[OutW-1:1] == '0, "result padding not zero")

  // Reset empties the pipeline.
  `SOT_ASSERT_ALWAYS(a_reset_empty, rst, !m_tvalid, "result item offered straight after reset")

endmodule

bind sphere_obb_overlap_test_top sot_checker u_sot_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
